@@ rtl/core/dqe_pkg.sv @@
// Package for the double-ended queue: ring size, derived widths,
// operation and status codes.
// No dependencies.
`default_nettype none

package dqe_pkg;

   localparam int DEPTH  = 16;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = PTR_W + 1;
   localparam int DATA_W = 32;
   localparam int LEN_W  = 5;
   localparam int FILL_W = 5;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

endpackage

`default_nettype wire

@@ rtl/core/dqe_if.sv @@
// Valid/ready channel interfaces for the queue request and response.
// Depends on dqe_pkg.
`default_nettype none

interface dqe_req_if import dqe_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               op;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface dqe_rsp_if import dqe_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] popped_value;
   logic [1:0]               status;
   logic [FILL_W-1:0]        fill_count;

   modport source (output valid, output popped_value, output status, output fill_count,
                   input ready);
   modport sink   (input valid, input popped_value, input status, input fill_count,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/core/double_ended_queue_top.sv @@
// Channel     | dir | payload
// req_ch      | in  | op, value
// rsp_ch      | out | popped_value, status, fill_count
// csr_wr_*    | in  | max_length (5 bits)
//
// One transaction per cycle while rsp_ch is not stalled; each request yields its response in the next cycle.
// Entries sit in a synchronous ring memory; front pointer and count are registers.
// A pop's read is issued at accept and lands in the response stage next cycle.
// The response register holds while rsp_ch stalls; req_ch.ready drops only then.
// Reset clears pointer and count and sets the limit to 16; memory is not cleared.
// Depends on dqe_pkg and dqe_if.
`default_nettype none

module double_ended_queue_top import dqe_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   dqe_req_if.sink            req_ch,
   dqe_rsp_if.source          rsp_ch,
   input  wire logic          csr_wr_en,
   input  wire logic [LEN_W-1:0] csr_wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   logic [PTR_W-1:0]  front_ff, front_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [LEN_W-1:0]  max_len_ff;
   logic              rsp_valid_ff;
   logic              pop_done_ff;
   status_type        status_ff, status_in;
   logic [DATA_W-1:0] rd_ff;

   logic              accept;
   logic [CNT_W-1:0]  limit;
   logic [SUM_W-1:0]  back_sum, last_sum;
   logic [PTR_W-1:0]  back_slot, last_slot, front_dec, front_inc;
   logic              wr_en, rd_en, pop_ok;
   logic [PTR_W-1:0]  wr_addr, rd_addr;
   op_type            op;

   assign op         = op_type'(req_ch.op);
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept     = req_ch.valid && req_ch.ready;

   assign limit = (32'(max_len_ff) > 32'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(max_len_ff);

   assign back_sum  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign last_sum  = back_sum - SUM_W'(1);
   assign back_slot = (back_sum >= SUM_W'(DEPTH)) ? PTR_W'(back_sum - SUM_W'(DEPTH))
                                                  : PTR_W'(back_sum);
   assign last_slot = (last_sum >= SUM_W'(DEPTH)) ? PTR_W'(last_sum - SUM_W'(DEPTH))
                                                  : PTR_W'(last_sum);
   assign front_dec = (front_ff == '0) ? PTR_W'(DEPTH - 1) : front_ff - PTR_W'(1);
   assign front_inc = (front_ff == PTR_W'(DEPTH - 1)) ? '0 : front_ff + PTR_W'(1);

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = ST_DONE;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      pop_ok    = 1'b0;
      wr_addr   = back_slot;
      rd_addr   = front_ff;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (count_ff >= limit) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = accept;
               count_in = count_ff + CNT_W'(1);
               if (op == OP_PUSH_FRONT) begin
                  wr_addr  = front_dec;
                  front_in = front_dec;
               end
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               pop_ok   = 1'b1;
               rd_en    = accept;
               count_in = count_ff - CNT_W'(1);
               if (op == OP_POP_FRONT) begin
                  front_in = front_inc;
               end else begin
                  rd_addr = last_slot;
               end
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_ch.value;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
      if (accept) begin
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         max_len_ff   <= LEN_W'(16);
         rsp_valid_ff <= 1'b0;
         pop_done_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         if (accept) begin
            front_ff     <= front_in;
            count_ff     <= count_in;
            pop_done_ff  <= pop_ok;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.popped_value = pop_done_ff ? rd_ff : '0;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.fill_count   = FILL_W'(count_ff);

endmodule

`default_nettype wire

@@ tb/sv/tb_double_ended_queue_top.sv @@
// Self-checking testbench for double_ended_queue_top: random and directed push/pop
// transactions with an in-order deque predictor and per-field response checks.
// Depends on dqe_pkg, dqe_if and the double_ended_queue_top RTL.
`default_nettype none

module tb_double_ended_queue_top import dqe_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 117;

   typedef struct {
      op_type                   op;
      logic signed [DATA_W-1:0] value;
   } deque_cmd_type;

   typedef struct {
      logic signed [DATA_W-1:0] popped;
      status_type               status;
      logic [FILL_W-1:0]        fill;
   } deque_result_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [LEN_W-1:0] csr_wr_data;

   dqe_req_if req ();
   dqe_rsp_if rsp ();

   double_ended_queue_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req),
      .rsp_ch      (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   logic signed [DATA_W-1:0] ring [DEPTH];
   logic [PTR_W-1:0]         head = '0;
   logic [CNT_W-1:0]         held = '0;
   logic [LEN_W-1:0]         limit_reg = LEN_W'(16);

   deque_cmd_type    req_backlog[$];
   deque_result_type rsp_due[$];
   int unsigned   items_queued = 0;
   int unsigned   responses_seen = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   send_idle_pct = 13;
   int unsigned   recv_idle_pct = 75;
   int            stall_cycles = 0;

   function automatic deque_result_type apply_deque_op(deque_cmd_type c);
      deque_result_type r;
      int unsigned      lim;
      logic [PTR_W-1:0] slot;
      r.popped = '0;
      r.status = ST_DONE;
      lim = (limit_reg > DEPTH) ? DEPTH : limit_reg;
      case (c.op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (held >= lim) begin
               r.status = ST_FULL;
            end else if (c.op == OP_PUSH_FRONT) begin
               head = head - 1'b1;
               ring[head] = c.value;
               held = held + 1'b1;
            end else begin
               slot = head + held[PTR_W-1:0];
               ring[slot] = c.value;
               held = held + 1'b1;
            end
         end
         default: begin
            if (held == 0) begin
               r.status = ST_EMPTY;
            end else if (c.op == OP_POP_FRONT) begin
               r.popped = ring[head];
               head = head + 1'b1;
               held = held - 1'b1;
            end else begin
               slot = head + held[PTR_W-1:0] - 1'b1;
               r.popped = ring[slot];
               held = held - 1'b1;
            end
         end
      endcase
      r.fill = FILL_W'(held);
      return r;
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 100) $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   task automatic queue_cmd(op_type op, logic signed [DATA_W-1:0] value);
      deque_cmd_type c;
      c.op = op;
      c.value = value;
      req_backlog.push_back(c);
      items_queued++;
   endtask

   function automatic deque_cmd_type random_cmd(int unsigned push_pct);
      deque_cmd_type c;
      if ($urandom_range(0, 99) < push_pct) begin
         c.op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
         c.op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      end
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: c.value = 32'sh8000_0000;
            1: c.value = 32'sh7FFF_FFFF;
            2: c.value = '0;
            default: c.value = -32'sd1;
         endcase
      end else begin
         c.value = $urandom();
      end
      return c;
   endfunction

   task automatic wait_idle();
      do @(posedge clock); while (responses_seen != items_queued);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_limit(logic [LEN_W-1:0] v);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_reg = v;
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin : req_driver
      deque_cmd_type c;
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            c.op = op_type'(req.op);
            c.value = req.value;
            rsp_due.push_back(apply_deque_op(c));
         end
         if (!req.valid || req.ready) begin
            if (req_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               c = req_backlog.pop_front();
               req.valid <= 1'b1;
               req.op <= c.op;
               req.value <= c.value;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      deque_result_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (rsp_due.size() == 0) begin
               report_mismatch("response with no transaction outstanding");
            end else begin
               want = rsp_due.pop_front();
               if (rsp.popped_value !== want.popped)
                  report_mismatch($sformatf("popped_value got %0d want %0d",
                                            rsp.popped_value, want.popped));
               if (rsp.status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp.status, want.status));
               if (rsp.fill_count !== want.fill)
                  report_mismatch($sformatf("fill_count got %0d want %0d",
                                            rsp.fill_count, want.fill));
            end
            responses_seen++;
         end
         rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("** double_ended_queue_top: FAILED **");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [LEN_W-1:0] limits [12];
      int unsigned      bias;
      reset = 1'b1;
      req.valid = 1'b0;
      req.op = '0;
      req.value = '0;
      rsp.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      limits = '{5'd3, 5'd0, 5'd1, 5'd31, 5'd17, 5'd16, 5'd2, 5'd8, 5'd16, 5'd5,
                 5'd12, 5'd15};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty pops, value extremes, fill to the ring size, push when full
      queue_cmd(OP_POP_FRONT, 32'sh7FFF_FFFF);
      queue_cmd(OP_POP_BACK, 32'sh8000_0000);
      queue_cmd(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
      queue_cmd(OP_PUSH_BACK, 32'sh8000_0000);
      queue_cmd(OP_POP_BACK, '0);
      queue_cmd(OP_POP_FRONT, -32'sd1);
      queue_cmd(OP_POP_FRONT, '0);
      for (int k = 0; k < DEPTH; k++)
         queue_cmd(k[0] ? OP_PUSH_BACK : OP_PUSH_FRONT,
                   (k == 3) ? -32'sd1 : (k == 6) ? '0 : $urandom());
      queue_cmd(OP_PUSH_BACK, 32'sh1234_5678);
      queue_cmd(OP_PUSH_FRONT, 32'sh1234_5678);
      queue_cmd(OP_POP_FRONT, '0);
      queue_cmd(OP_POP_BACK, '0);

      // queue still holds entries when the limit first drops below the count
      for (int p = 0; p < 12; p++) begin
         wait_idle();
         case (p / 4)
            0: begin send_idle_pct = 13; recv_idle_pct = 75; end
            1: begin send_idle_pct = 75; recv_idle_pct = 13; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         write_limit(limits[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 20 == 0) begin
               case ($urandom_range(0, 2))
                  0: bias = 85;
                  1: bias = 50;
                  default: bias = 15;
               endcase
            end
            req_backlog.push_back(random_cmd(bias));
            items_queued++;
         end
      end

      wait_idle();
      repeat (6) @(posedge clock);
      if (rsp_due.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", rsp_due.size()));
      if (mismatch_count == 0) begin
         $display("** double_ended_queue_top: PASSED **");
      end else begin
         $display("** double_ended_queue_top: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
rtl/core/dqe_pkg.sv
rtl/core/dqe_if.sv
rtl/core/double_ended_queue_top.sv
tb/sv/tb_double_ended_queue_top.sv
